[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the metadata property parser.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define MPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MPP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/mpp_pkg.sv]
// ---------------------------------------------------------------------------
// mpp_pkg
// Types, codes and name tables of the metadata property parser.
// ---------------------------------------------------------------------------
package mpp_pkg;

  localparam int NumTypes = 7;

  typedef enum logic [3:0] {
    PH_NLEN = 4'b0001,
    PH_NAME = 4'b0010,
    PH_VLEN = 4'b0100,
    PH_VAL  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_NLEN = 2'd0,
    ROLE_NAME = 2'd1,
    ROLE_VLEN = 2'd2,
    ROLE_VAL  = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_IDENT = 2'd1,
    KIND_STYPE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_TRUNC  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_OWN_TYPE   = 1'b0,
    CFG_ROUTING_ID = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    role_e      role;
    logic [7:0] data;
    kind_e      kind;
    logic       rid;
    logic       prop_end;
    status_e    status;
    logic       done;
  } res_t;

  localparam logic [63:0] IDENT_STR = "Identity";
  localparam logic [87:0] STYPE_STR = "Socket-Type";

  // Peer type names, right-justified in 48 bits
  localparam logic [47:0] TYPE_STR [NumTypes] = '{
    "PAIR", "PUB", "SUB", "DEALER", "ROUTER", "XPUB", "XSUB"
  };
  localparam logic [2:0] TYPE_LEN [NumTypes] = '{
    3'd4, 3'd3, 3'd3, 3'd6, 3'd6, 3'd4, 3'd4
  };

  // Bit i set: peer type i accepted, indexed by own socket type
  localparam logic [NumTypes-1:0] ALLOWED_PEERS [8] = '{
    7'h01, 7'h44, 7'h22, 7'h18, 7'h18, 7'h44, 7'h22, 7'h00
  };

  function automatic logic ident_hit(logic [3:0] idx, logic [7:0] b);
    logic hit;
    hit = 1'b0;
    if (idx < 4'd8) begin
      hit = (IDENT_STR[8 * (7 - int'(idx)) +: 8] == b);
    end
    return hit;
  endfunction

  function automatic logic stype_hit(logic [3:0] idx, logic [7:0] b);
    logic hit;
    hit = 1'b0;
    if (idx < 4'd11) begin
      hit = (STYPE_STR[8 * (10 - int'(idx)) +: 8] == b);
    end
    return hit;
  endfunction

  function automatic logic type_hit(int t, logic [2:0] vi, logic [7:0] b);
    logic [2:0] len;
    logic       hit;
    len = TYPE_LEN[t];
    hit = 1'b0;
    if (vi < len) begin
      hit = (TYPE_STR[t][8 * (int'(len) - 1 - int'(vi)) +: 8] == b);
    end
    return hit;
  endfunction

endpackage

[design/mpp_in_stage.sv]
// ---------------------------------------------------------------------------
// mpp_in_stage
// Input register: holds one accepted item until the parser takes it.
// ---------------------------------------------------------------------------
module mpp_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  mpp_pkg::item_t item_i,
  input  logic          take_i,
  output logic          valid_o,
  output mpp_pkg::item_t item_o
);
  import mpp_pkg::*;

  logic  vld_q;
  item_t item_q;

  assign ready_o = !vld_q || take_i;
  assign valid_o = vld_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

[design/mpp_parse_core.sv]
// ---------------------------------------------------------------------------
// mpp_parse_core
// Per-byte property parser: parse state and the one-byte step logic.
// ---------------------------------------------------------------------------
module mpp_parse_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mpp_pkg::item_t item_i,
  input  logic           step_i,
  input  logic [2:0]     own_type_i,
  input  logic           rid_en_i,
  output mpp_pkg::res_t  res_o
);
  import mpp_pkg::*;

  phase_e              phase_q, phase_d;
  logic [31:0]         rem_q, rem_d;
  logic [1:0]          shift_q, shift_d;
  logic [1:0]          nmatch_q, nmatch_d;
  logic [3:0]          nidx_q, nidx_d;
  kind_e               kind_q, kind_d;
  logic [NumTypes-1:0] tmatch_q, tmatch_d;
  logic [2:0]          vidx_q, vidx_d;
  status_e             err_q, err_d;

  logic [7:0]          b;
  logic [31:0]         rem_dec;
  logic [31:0]         vlen_full;
  logic [NumTypes-1:0] len_hit;
  logic [NumTypes-1:0] char_hit;
  role_e               role;
  kind_e               kind_out;
  logic                rid;
  logic                pend;
  logic                end_name;
  status_e             status;

  assign b         = item_i.data;
  assign rem_dec   = rem_q - 32'd1;
  assign vlen_full = {rem_q[23:0], b};

  always_comb begin
    for (int t = 0; t < NumTypes; t++) begin
      len_hit[t]  = ({29'd0, TYPE_LEN[t]} == vlen_full);
      char_hit[t] = type_hit(t, vidx_q, b);
    end
  end

  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    shift_d  = shift_q;
    nmatch_d = nmatch_q;
    nidx_d   = nidx_q;
    kind_d   = kind_q;
    tmatch_d = tmatch_q;
    vidx_d   = vidx_q;
    err_d    = err_q;
    role     = ROLE_NLEN;
    kind_out = KIND_OTHER;
    rid      = 1'b0;
    pend     = 1'b0;
    end_name = 1'b0;

    if (err_q == ST_OK) begin
      case (phase_q)
        PH_NLEN: begin
          role     = ROLE_NLEN;
          rem_d    = {24'd0, b};
          nidx_d   = '0;
          nmatch_d = {b == 8'd11, b == 8'd8};
          if (b == 8'd0) begin
            end_name = 1'b1;
          end else begin
            phase_d = PH_NAME;
          end
        end
        PH_NAME: begin
          role     = ROLE_NAME;
          nmatch_d = nmatch_q & {stype_hit(nidx_q, b), ident_hit(nidx_q, b)};
          // saturate: past both names nothing can match anyway
          nidx_d   = (nidx_q == 4'd11) ? nidx_q : nidx_q + 4'd1;
          rem_d    = rem_dec;
          if (rem_dec == 32'd0) begin
            end_name = 1'b1;
          end
        end
        PH_VLEN: begin
          role     = ROLE_VLEN;
          kind_out = kind_q;
          rem_d    = vlen_full;
          shift_d  = shift_q + 2'd1;
          if (shift_q == 2'd3) begin
            tmatch_d = len_hit;
            vidx_d   = '0;
            if (vlen_full == 32'd0) begin
              pend = 1'b1;
            end else begin
              phase_d = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          role     = ROLE_VAL;
          kind_out = kind_q;
          rid      = (kind_q == KIND_IDENT) && rid_en_i;
          tmatch_d = tmatch_q & char_hit;
          vidx_d   = (vidx_q == 3'd7) ? vidx_q : vidx_q + 3'd1;
          rem_d    = rem_dec;
          if (rem_dec == 32'd0) begin
            pend = 1'b1;
          end
        end
        default: begin
          phase_d = PH_NLEN;
        end
      endcase
    end

    if (end_name) begin
      if (nmatch_d[0]) begin
        kind_d = KIND_IDENT;
      end else if (nmatch_d[1]) begin
        kind_d = KIND_STYPE;
      end else begin
        kind_d = KIND_OTHER;
      end
      phase_d = PH_VLEN;
      shift_d = '0;
      rem_d   = '0;
    end

    // Property complete: check the peer socket type
    if (pend) begin
      phase_d = PH_NLEN;
      if (kind_q == KIND_STYPE && (tmatch_d & ALLOWED_PEERS[own_type_i]) == '0) begin
        err_d = ST_REJECT;
      end
    end

    status = err_d;
    if (item_i.last && err_d == ST_OK && !pend) begin
      status = ST_TRUNC;
    end

    // End of buffer: drop all parse state
    if (item_i.last) begin
      phase_d  = PH_NLEN;
      rem_d    = '0;
      shift_d  = '0;
      nmatch_d = 2'b11;
      nidx_d   = '0;
      kind_d   = KIND_OTHER;
      tmatch_d = '1;
      vidx_d   = '0;
      err_d    = ST_OK;
    end
  end

  assign res_o.role     = role;
  assign res_o.data     = b;
  assign res_o.kind     = kind_out;
  assign res_o.rid      = rid;
  assign res_o.prop_end = pend;
  assign res_o.status   = status;
  assign res_o.done     = item_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NLEN;
      rem_q    <= '0;
      shift_q  <= '0;
      nmatch_q <= 2'b11;
      nidx_q   <= '0;
      kind_q   <= KIND_OTHER;
      tmatch_q <= '1;
      vidx_q   <= '0;
      err_q    <= ST_OK;
    end else if (step_i) begin
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      shift_q  <= shift_d;
      nmatch_q <= nmatch_d;
      nidx_q   <= nidx_d;
      kind_q   <= kind_d;
      tmatch_q <= tmatch_d;
      vidx_q   <= vidx_d;
      err_q    <= err_d;
    end
  end

endmodule

[design/mpp_out_stage.sv]
// ---------------------------------------------------------------------------
// mpp_out_stage
// Result register: holds one result item until the receiver takes it.
// ---------------------------------------------------------------------------
module mpp_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  mpp_pkg::res_t res_i,
  input  logic          ready_i,
  output logic          valid_o,
  output mpp_pkg::res_t res_o
);
  import mpp_pkg::*;

  logic vld_q;
  res_t res_q;

  assign valid_o = vld_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[design/metadata_property_parser_unit.sv]
// ---------------------------------------------------------------------------
// metadata_property_parser_unit
// Byte-stream parser for handshake metadata properties.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one buffer byte per item,
//   with last_byte_i marking the final byte. Output channel
//   (out_valid_o/out_ready_i) gives one result item per input item, in
//   order: role tag, byte, name kind, routing id flag, property end and
//   the sticky status (final when done_res_o is high).
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 own socket type, 1 routing id enable) at once; write only while idle.
//   Path: an accepted item enters the input register, then the parse step
//   loads its result into the result register.
//   Throughput: one item per cycle while out_ready_i is high; the parse
//   state updates once per byte in a single step between the two registers.
//   Stall: while the receiver holds out_ready_i low the result register
//   holds; the input register still takes one more item, then in_ready_o
//   drops until the result moves on.
//   Reset: clears both registers' valid bits, the parse state and the
//   configuration registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module metadata_property_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] byte_role_o,
  output logic [7:0] byte_out_o,
  output logic [1:0] name_kind_o,
  output logic       routing_id_byte_o,
  output logic       property_end_o,
  output logic [1:0] status_o,
  output logic       done_res_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [2:0] cfg_data_i
);
  import mpp_pkg::*;

  logic [2:0] own_q;
  logic       rid_en_q;
  item_t      in_item;
  item_t      stage_item;
  logic       stage_vld;
  logic       advance;
  res_t       step_res;
  res_t       out_res;

  assign in_item.data = data_byte_i;
  assign in_item.last = last_byte_i;

  // Move the held item into the result register when that slot is free
  assign advance = stage_vld && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q    <= '0;
      rid_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OWN_TYPE:   own_q    <= cfg_data_i;
        CFG_ROUTING_ID: rid_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mpp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .take_i  (advance),
    .valid_o (stage_vld),
    .item_o  (stage_item)
  );

  mpp_parse_core u_parse_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (stage_item),
    .step_i     (advance),
    .own_type_i (own_q),
    .rid_en_i   (rid_en_q),
    .res_o      (step_res)
  );

  mpp_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (step_res),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign byte_role_o       = out_res.role;
  assign byte_out_o        = out_res.data;
  assign name_kind_o       = out_res.kind;
  assign routing_id_byte_o = out_res.rid;
  assign property_end_o    = out_res.prop_end;
  assign status_o          = out_res.status;
  assign done_res_o        = out_res.done;

  `MPP_ASSERT_IMPL(a_done_ok_ends_prop, out_valid_o && done_res_o && status_o == ST_OK, property_end_o, "last byte with ok status did not complete a property")
  `MPP_ASSERT_IMPL(a_rid_tag, out_valid_o && routing_id_byte_o, byte_role_o == ROLE_VAL && name_kind_o == KIND_IDENT, "routing id flag on a byte that is not an identity value byte")
  `MPP_ASSERT_IMPL(a_stall_only_when_full, !in_ready_o, stage_vld && out_valid_o && !out_ready_i, "input stalled while the result path can move")

endmodule

[tb/tb_metadata_property_parser_unit.sv]
// ---------------------------------------------------------------------------
// tb_metadata_property_parser_unit
// Drives metadata buffers byte by byte into the property parser, predicts
// every result item (role tag, name kind, routing id flag, property end,
// sticky status) with a parser model kept in the testbench, and compares
// each field in order. Covers empty fields, truncation, peer type rejection,
// all own socket types, random buffers with gaps and stalls, and a long
// receiver hold that backs up the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_metadata_property_parser_unit;
  import mpp_pkg::*;

  localparam int ItemsPerSetting = 190;
  localparam int PressureItems   = 300;
  localparam int HoldCycles      = 250;
  localparam int WatchdogLimit   = 2000;
  localparam int MaxPrinted      = 50;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'd0;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] byte_role_o;
  logic [7:0] byte_out_o;
  logic [1:0] name_kind_o;
  logic       routing_id_byte_o;
  logic       property_end_o;
  logic [1:0] status_o;
  logic       done_res_o;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = CFG_OWN_TYPE;
  logic [2:0] cfg_data_i = 3'd0;

  metadata_property_parser_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .byte_role_o       (byte_role_o),
    .byte_out_o        (byte_out_o),
    .name_kind_o       (name_kind_o),
    .routing_id_byte_o (routing_id_byte_o),
    .property_end_o    (property_end_o),
    .status_o          (status_o),
    .done_res_o        (done_res_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Property names and peer types as the parser knows them
  string ident_txt = "Identity";
  string stype_txt = "Socket-Type";
  string peer_names [NumTypes] = '{"PAIR", "PUB", "SUB", "DEALER", "ROUTER", "XPUB", "XSUB"};
  int peer_len [NumTypes] = '{4, 3, 3, 6, 6, 4, 4};
  logic [NumTypes-1:0] peer_accept [8] = '{
    7'h01, 7'h44, 7'h22, 7'h18, 7'h18, 7'h44, 7'h22, 7'h00
  };

  // Parser state mirrored by the testbench
  logic [2:0]          cfg_own_type;
  logic                cfg_rid_en;
  role_e               pe_phase;
  logic [31:0]         pe_remain;
  int                  pe_shift;
  logic [1:0]          pe_name_hits;
  logic [7:0]          pe_name_idx;
  kind_e               pe_kind;
  logic [NumTypes-1:0] pe_type_hits;
  logic [2:0]          pe_val_idx;
  status_e             pe_err;

  res_t       tag_q [$];
  logic [7:0] frame_q [$];
  logic [7:0] name_q [$];
  logic [7:0] value_q [$];
  logic [7:0] txt_q [$];

  int mismatch_cnt = 0;
  int result_cnt = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  bit rx_hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_parse();
    pe_phase = ROLE_NLEN;
    pe_remain = '0;
    pe_shift = 0;
    pe_name_hits = 2'b11;
    pe_name_idx = '0;
    pe_kind = KIND_OTHER;
    pe_type_hits = '1;
    pe_val_idx = '0;
    pe_err = ST_OK;
  endfunction

  function automatic void close_name();
    if (pe_name_hits[0]) begin
      pe_kind = KIND_IDENT;
    end else if (pe_name_hits[1]) begin
      pe_kind = KIND_STYPE;
    end else begin
      pe_kind = KIND_OTHER;
    end
    pe_phase = ROLE_VLEN;
    pe_shift = 0;
    pe_remain = '0;
  endfunction

  // A Socket-Type property is judged on its completing byte
  function automatic void close_property();
    if (pe_kind == KIND_STYPE && (pe_type_hits & peer_accept[cfg_own_type]) == '0) begin
      pe_err = ST_REJECT;
    end
    pe_phase = ROLE_NLEN;
  endfunction

  function automatic res_t parse_byte(input logic [7:0] b, input logic last);
    res_t r;
    logic prop_done;
    int   i;
    r.role = ROLE_NLEN;
    r.data = b;
    r.kind = KIND_OTHER;
    r.rid = 1'b0;
    prop_done = 1'b0;
    if (pe_err == ST_OK) begin
      r.role = pe_phase;
      case (pe_phase)
        ROLE_NLEN: begin
          pe_remain = {24'd0, b};
          pe_name_idx = '0;
          pe_name_hits = {b == 8'd11, b == 8'd8};
          if (b == 8'd0) begin
            close_name();
          end else begin
            pe_phase = ROLE_NAME;
          end
        end
        ROLE_NAME: begin
          if (pe_name_idx >= 8 || ident_txt[pe_name_idx] != b) pe_name_hits[0] = 1'b0;
          if (pe_name_idx >= 11 || stype_txt[pe_name_idx] != b) pe_name_hits[1] = 1'b0;
          pe_name_idx++;
          pe_remain--;
          if (pe_remain == 0) close_name();
        end
        ROLE_VLEN: begin
          r.kind = pe_kind;
          pe_remain = {pe_remain[23:0], b};
          pe_shift++;
          if (pe_shift == 4) begin
            pe_shift = 0;
            for (i = 0; i < NumTypes; i++) begin
              pe_type_hits[i] = (peer_len[i] == pe_remain);
            end
            pe_val_idx = '0;
            if (pe_remain == 0) begin
              close_property();
              prop_done = 1'b1;
            end else begin
              pe_phase = ROLE_VAL;
            end
          end
        end
        default: begin
          r.kind = pe_kind;
          r.rid = (pe_kind == KIND_IDENT) && cfg_rid_en;
          for (i = 0; i < NumTypes; i++) begin
            if (pe_type_hits[i] &&
                (pe_val_idx >= peer_len[i] || peer_names[i][pe_val_idx] != b)) begin
              pe_type_hits[i] = 1'b0;
            end
          end
          if (pe_val_idx < 3'd7) pe_val_idx++;
          pe_remain--;
          if (pe_remain == 0) begin
            close_property();
            prop_done = 1'b1;
          end
        end
      endcase
    end
    r.prop_end = prop_done;
    r.status = pe_err;
    if (last && pe_err == ST_OK && !prop_done) r.status = ST_TRUNC;
    r.done = last;
    if (last) clear_parse();
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tag_q.push_back(parse_byte(b, last));
    items_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // Drop valid and wait for every pending result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tag_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [2:0] own_type, input logic rid_en);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_OWN_TYPE;
    cfg_data_i <= own_type;
    @(posedge clk_i);
    cfg_own_type = own_type;
    cfg_index_i <= CFG_ROUTING_ID;
    cfg_data_i <= {2'($urandom_range(0, 3)), rid_en};
    @(posedge clk_i);
    cfg_rid_en = rid_en;
    cfg_we_i <= 1'b0;
  endtask

  function automatic void load_text(input string s);
    int i;
    txt_q.delete();
    for (i = 0; i < s.len(); i++) txt_q.push_back(s[i]);
  endfunction

  // Near miss: flip a bit, drop the tail or add a byte
  function automatic void mangle_text();
    int m;
    int j;
    m = $urandom_range(0, 2);
    if (m == 0 && txt_q.size() > 0) begin
      j = $urandom_range(0, txt_q.size() - 1);
      txt_q[j] = txt_q[j] ^ (8'd1 << $urandom_range(0, 7));
    end else if (m == 1 && txt_q.size() > 0) begin
      void'(txt_q.pop_back());
    end else begin
      txt_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic kind_e pick_name();
    int    r;
    kind_e k;
    r = $urandom_range(0, 99);
    k = KIND_OTHER;
    txt_q.delete();
    if (r < 35) begin
      load_text(ident_txt);
      k = KIND_IDENT;
    end else if (r < 70) begin
      load_text(stype_txt);
      k = KIND_STYPE;
    end else if (r < 82) begin
      load_text(r[0] ? ident_txt : stype_txt);
      mangle_text();
    end else begin
      repeat ($urandom_range(0, 12)) txt_q.push_back(8'($urandom_range(0, 255)));
    end
    name_q = txt_q;
    return k;
  endfunction

  function automatic void pick_value(input kind_e k);
    int r;
    r = $urandom_range(0, 99);
    txt_q.delete();
    if (k == KIND_STYPE && r < 60) begin
      load_text(peer_names[$urandom_range(0, NumTypes - 1)]);
    end else if (k == KIND_STYPE && r < 72) begin
      load_text(peer_names[$urandom_range(0, NumTypes - 1)]);
      mangle_text();
    end else if (k == KIND_STYPE && r < 82) begin
      // longer than any peer type name
      load_text(r[0] ? "DEALER" : "ROUTER");
      repeat ($urandom_range(1, 4)) txt_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, k == KIND_IDENT ? 8 : 6)) begin
        txt_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    value_q = txt_q;
  endfunction

  function automatic void append_property();
    logic [31:0] vlen;
    int          i;
    vlen = value_q.size();
    frame_q.push_back(8'(name_q.size()));
    for (i = 0; i < name_q.size(); i++) frame_q.push_back(name_q[i]);
    frame_q.push_back(vlen[31:24]);
    frame_q.push_back(vlen[23:16]);
    frame_q.push_back(vlen[15:8]);
    frame_q.push_back(vlen[7:0]);
    for (i = 0; i < value_q.size(); i++) frame_q.push_back(value_q[i]);
  endfunction

  // Mostly well-formed buffers; some cut short, some noise
  task automatic send_buffer();
    int    r;
    int    cut;
    int    n;
    kind_e k;
    frame_q.delete();
    repeat ($urandom_range(1, 3)) begin
      k = pick_name();
      pick_value(k);
      append_property();
    end
    r = $urandom_range(0, 99);
    if (r >= 80 && r < 90) begin
      if (frame_q.size() > 1) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end else if (r >= 90 && r < 95) begin
      // huge value length, buffer ends long before the value does
      frame_q.delete();
      n = $urandom_range(0, 3);
      frame_q.push_back(8'(n));
      repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(8'($urandom_range(1, 255)));
      repeat (3) frame_q.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else if (r >= 95) begin
      frame_q.delete();
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    send_frame();
  endtask

  task automatic test_empty_fields();
    // empty name, then an empty value completing on the fourth length byte
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
  endtask

  task automatic test_truncation();
    // a lone name length byte
    frame_q = '{8'hFF};
    send_frame();
  endtask

  task automatic test_type_rejection();
    // SUB is not a valid peer of PAIR; the trailing byte is ignored
    frame_q.delete();
    load_text(stype_txt);
    name_q = txt_q;
    load_text("SUB");
    value_q = txt_q;
    append_property();
    frame_q.push_back(8'hFF);
    send_frame();
  endtask

  task automatic test_config_sweep();
    int k;
    int start;
    for (k = 0; k < 8; k++) begin
      write_config(3'((k * 5) % 8), k[0]);
      tx_gaps_on = (k % 3 != 0);
      rx_stalls_on = (k % 4 != 1);
      start = items_sent;
      while (items_sent - start < ItemsPerSetting) send_buffer();
    end
  endtask

  task automatic test_backpressure();
    int start;
    write_config(3'($urandom_range(0, 7)), 1'b1);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b1;
    rx_hold_req = 1'b1;
    start = items_sent;
    while (items_sent - start < PressureItems) send_buffer();
  endtask

  initial begin : drive_ready
    int run_len;
    int low_len;
    run_len = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (!rx_stalls_on || run_len > 0) begin
        out_ready_i <= 1'b1;
        if (run_len > 0) run_len--;
      end else begin
        out_ready_i <= 1'b0;
        low_len = gap_len();
        repeat (low_len) @(posedge clk_i);
        run_len = $urandom_range(0, 40);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      result_cnt++;
      if (tag_q.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no item pending", result_cnt));
      end else begin
        want = tag_q.pop_front();
        if (byte_role_o !== want.role)
          flag_error($sformatf("result %0d byte_role %0d, want %0d",
                               result_cnt, byte_role_o, want.role));
        if (byte_out_o !== want.data)
          flag_error($sformatf("result %0d byte_out %0h, want %0h",
                               result_cnt, byte_out_o, want.data));
        if (name_kind_o !== want.kind)
          flag_error($sformatf("result %0d name_kind %0d, want %0d",
                               result_cnt, name_kind_o, want.kind));
        if (routing_id_byte_o !== want.rid)
          flag_error($sformatf("result %0d routing_id_byte %0d, want %0d",
                               result_cnt, routing_id_byte_o, want.rid));
        if (property_end_o !== want.prop_end)
          flag_error($sformatf("result %0d property_end %0d, want %0d",
                               result_cnt, property_end_o, want.prop_end));
        if (status_o !== want.status)
          flag_error($sformatf("result %0d status %0d, want %0d",
                               result_cnt, status_o, want.status));
        if (done_res_o !== want.done)
          flag_error($sformatf("result %0d done_res %0d, want %0d",
                               result_cnt, done_res_o, want.done));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL metadata_property_parser_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_own_type = 3'd0;
    cfg_rid_en = 1'b0;
    clear_parse();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_fields();
    test_truncation();
    test_type_rejection();
    test_config_sweep();
    test_backpressure();
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && tag_q.size() == 0) begin
      $display("PASS metadata_property_parser_unit");
    end else begin
      $display("FAIL metadata_property_parser_unit");
    end
    $finish;
  end

endmodule
